// ----- rtl/aehi_pkg.sv -----
// Shared types and constants for the embedded controller host interface.
package aehi_pkg;

   // Register file address width; the file holds 2**ADDR_BITS bytes
   localparam int ADDR_BITS = 8;
   localparam int RF_DEPTH  = 2 ** ADDR_BITS;

   // Command port bytes
   localparam logic [7:0] EC_CMD_READ  = 8'h80;
   localparam logic [7:0] EC_CMD_WRITE = 8'h81;

   // Status byte bits
   localparam logic [7:0] STAT_OBF = 8'h01;
   localparam logic [7:0] STAT_IBF = 8'h02;
   localparam logic [7:0] STAT_CMD = 8'h08;

   // Host access kinds
   typedef enum logic [1:0] {
      HOST_STATUS_RD = 2'd0,
      HOST_CMD_WR    = 2'd1,
      HOST_DATA_RD   = 2'd2,
      HOST_DATA_WR   = 2'd3
   } host_op_type;

   // Transaction phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RADDR = 2'd1,
      PH_WADDR = 2'd2,
      PH_WDATA = 2'd3
   } phase_type;

   // Register file write request
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           data;
   } rf_write_type;

   // Register file read request
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } rf_read_type;

endpackage

// ----- rtl/aehi_regfile.sv -----
// Byte register file with per-entry valid bits and write-to-read forwarding.
module aehi_regfile
   import aehi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rf_write_type wr,
   input  rf_read_type  rd,
   output logic [7:0]   rd_data
);

   logic [7:0]          mem [RF_DEPTH];
   logic [RF_DEPTH-1:0] valid_ff;
   logic [7:0]          rdata_ff;
   logic                vld_ff;
   logic                fwd_ff;
   logic [7:0]          fwd_data_ff;
   logic                hit;

   // same-edge write to the address being read
   assign hit = wr.en && (wr.addr == rd.addr);

   // storage array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rdata_ff    <= mem[rd.addr];
         fwd_ff      <= hit;
         fwd_data_ff <= wr.data;
      end
   end

   // valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            vld_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (vld_ff ? rdata_ff : 8'h00);

endmodule

// ----- rtl/acpi_ec_host_interface.sv -----
// Top level of the embedded controller host interface, device side.
// A transaction is held in the input register, and its response in the result register.
// Throughput: one transaction per cycle unless rsp_ready stalls; the register file read is issued at
// acceptance and its registered data is used in the decode stage.
// Reset: synchronous, active high; clears phase, flags, buffers and the
// register file valid bits, so every register file byte reads zero.
module acpi_ec_host_interface
   import aehi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_protocol_error
);

   // input stage
   logic        s1_valid_ff;
   host_op_type s1_command_ff;
   logic [7:0]  s1_data_ff;

   // controller state
   phase_type            phase_ff, phase_in;
   logic [ADDR_BITS-1:0] latched_address_ff, latched_address_in;
   logic [7:0]           output_buffer_ff, output_buffer_in;
   logic                 output_full_ff, output_full_in;
   logic                 last_was_command_ff, last_was_command_in;

   // result stage
   logic       rsp_valid_ff;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_error_ff, rsp_error_in;

   logic         advance;
   logic         accept;
   rf_write_type rf_wr;
   rf_read_type  rf_rd;
   logic [7:0]   rf_rd_data;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // register file lookup starts as the transaction is taken
   assign rf_rd.en   = accept;
   assign rf_rd.addr = req_write_data[ADDR_BITS-1:0];

   // store on the data byte of a write sequence
   assign rf_wr.en   = advance && (s1_command_ff == HOST_DATA_WR) && (phase_ff == PH_WDATA);
   assign rf_wr.addr = latched_address_ff;
   assign rf_wr.data = s1_data_ff;

   aehi_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (rf_wr),
      .rd      (rf_rd),
      .rd_data (rf_rd_data)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (accept) begin
         s1_command_ff <= host_op_type'(req_command);
         s1_data_ff    <= req_write_data;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (s1_command_ff)
         HOST_CMD_WR: begin
            if (s1_data_ff == EC_CMD_READ) begin
               phase_in = PH_RADDR;
            end else if (s1_data_ff == EC_CMD_WRITE) begin
               phase_in = PH_WADDR;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         HOST_DATA_WR: begin
            unique case (phase_ff)
               PH_RADDR: phase_in = PH_IDLE;
               PH_WADDR: phase_in = PH_WDATA;
               PH_WDATA: phase_in = PH_IDLE;
               PH_IDLE:  phase_in = PH_IDLE;
            endcase
         end
         HOST_STATUS_RD, HOST_DATA_RD: phase_in = phase_ff;
      endcase
   end

   // datapath and response
   always_comb begin
      latched_address_in  = latched_address_ff;
      output_buffer_in    = output_buffer_ff;
      output_full_in      = output_full_ff;
      last_was_command_in = last_was_command_ff;
      rsp_read_data_in    = 8'h00;
      rsp_error_in        = 1'b0;
      unique case (s1_command_ff)
         HOST_STATUS_RD: begin
            // IBF never set: each byte is consumed at once
            rsp_read_data_in = (output_full_ff ? STAT_OBF : 8'h00)
                             | (last_was_command_ff ? STAT_CMD : 8'h00)
                             | (STAT_IBF & 8'h00);
         end
         HOST_CMD_WR: begin
            last_was_command_in = 1'b1;
            rsp_error_in = (s1_data_ff != EC_CMD_READ) && (s1_data_ff != EC_CMD_WRITE);
         end
         HOST_DATA_RD: begin
            rsp_read_data_in = output_buffer_ff;
            output_full_in   = 1'b0;
            rsp_error_in     = !output_full_ff;
         end
         HOST_DATA_WR: begin
            last_was_command_in = 1'b0;
            unique case (phase_ff)
               PH_RADDR: begin
                  output_buffer_in = rf_rd_data;
                  output_full_in   = 1'b1;
               end
               PH_WADDR: latched_address_in = s1_data_ff[ADDR_BITS-1:0];
               PH_WDATA: ;
               PH_IDLE:  rsp_error_in = 1'b1;
            endcase
         end
      endcase
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         latched_address_ff  <= '0;
         output_buffer_ff    <= 8'h00;
         output_full_ff      <= 1'b0;
         last_was_command_ff <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff            <= phase_in;
            latched_address_ff  <= latched_address_in;
            output_buffer_ff    <= output_buffer_in;
            output_full_ff      <= output_full_in;
            last_was_command_ff <= last_was_command_in;
            rsp_valid_ff        <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_error_ff     <= rsp_error_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_protocol_error = rsp_error_ff;

endmodule

// ----- dv/tb_acpi_ec_host_interface.sv -----
// Self-checking testbench for the embedded controller host interface.
module tb_acpi_ec_host_interface;
   import aehi_pkg::*;

   localparam int RANDOM_ACCESSES = 1500;
   localparam int STALL_LIMIT     = 2000;
   localparam int MAX_PRINTS      = 40;

   typedef struct packed {
      logic [7:0] read_data;
      logic       protocol_error;
   } ec_result_type;

   // One row of the directed table; typed rows carry their own answer
   typedef struct {
      host_op_type op;
      logic [7:0]  byte_in;
      logic        typed;
      logic [7:0]  read_data;
      logic        protocol_error;
   } ec_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = HOST_STATUS_RD;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_protocol_error;

   // Predictor state
   phase_type            ec_phase;
   logic [ADDR_BITS-1:0] ec_wr_addr;
   logic [7:0]           ec_out_buf;
   logic                 ec_obf;
   logic                 ec_cmd_flag;
   logic [7:0]           ec_regs [RF_DEPTH];

   ec_result_type pending_q[$];
   ec_result_type got_result;
   ec_result_type want_result;

   logic calm = 1'b0;
   int   mismatches = 0;
   int   accesses = 0;
   int   responses = 0;
   int   stores = 0;
   int   loads = 0;
   int   flagged = 0;
   int   idle_cycles = 0;

   acpi_ec_host_interface uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_protocol_error (rsp_protocol_error)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Directed table: reset state, error paths, full store/load round trip,
   // abandoned transactions and buffer overwrite
   ec_row_type directed [] = '{
      '{HOST_STATUS_RD, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{HOST_DATA_RD,   8'h00, 1'b1, 8'h00, 1'b1},
      '{HOST_DATA_WR,   8'hFF, 1'b1, 8'h00, 1'b1},
      '{HOST_STATUS_RD, 8'h00, 1'b1, 8'h00, 1'b0},
      '{HOST_CMD_WR,    EC_CMD_WRITE, 1'b1, 8'h00, 1'b0},
      '{HOST_STATUS_RD, 8'h00, 1'b1, STAT_CMD, 1'b0},
      '{HOST_DATA_WR,   8'hFF, 1'b1, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'hA5, 1'b1, 8'h00, 1'b0},
      '{HOST_CMD_WR,    EC_CMD_READ, 1'b1, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'hFF, 1'b1, 8'h00, 1'b0},
      '{HOST_STATUS_RD, 8'h5A, 1'b1, STAT_OBF, 1'b0},
      '{HOST_DATA_RD,   8'h00, 1'b1, 8'hA5, 1'b0},
      '{HOST_DATA_RD,   8'h00, 1'b1, 8'hA5, 1'b1},
      '{HOST_CMD_WR,    8'h00, 1'b1, 8'h00, 1'b1},
      '{HOST_STATUS_RD, 8'h00, 1'b1, STAT_CMD, 1'b0},
      '{HOST_CMD_WR,    8'hFF, 1'b1, 8'h00, 1'b1},
      '{HOST_CMD_WR,    EC_CMD_WRITE, 1'b0, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'h00, 1'b0, 8'h00, 1'b0},
      '{HOST_CMD_WR,    EC_CMD_READ, 1'b0, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'h00, 1'b0, 8'h00, 1'b0},
      '{HOST_CMD_WR,    EC_CMD_READ, 1'b0, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'hFF, 1'b0, 8'h00, 1'b0},
      '{HOST_DATA_RD,   8'h00, 1'b0, 8'h00, 1'b0},
      '{HOST_DATA_WR,   8'h5A, 1'b0, 8'h00, 1'b0},
      '{HOST_STATUS_RD, 8'hFF, 1'b1, 8'h00, 1'b0}
   };

   function automatic void ec_clear_state();
      ec_phase    = PH_IDLE;
      ec_wr_addr  = '0;
      ec_out_buf  = 8'h00;
      ec_obf      = 1'b0;
      ec_cmd_flag = 1'b0;
      foreach (ec_regs[i]) ec_regs[i] = 8'h00;
   endfunction

   // Predict the answer to one host access and advance the port state
   function automatic ec_result_type ec_decode(host_op_type op, logic [7:0] b);
      ec_result_type r;
      r = '0;
      case (op)
         HOST_STATUS_RD: begin
            r.read_data = (ec_obf ? STAT_OBF : 8'h00) | (ec_cmd_flag ? STAT_CMD : 8'h00);
         end
         HOST_CMD_WR: begin
            ec_cmd_flag = 1'b1;
            if (b == EC_CMD_READ) ec_phase = PH_RADDR;
            else if (b == EC_CMD_WRITE) ec_phase = PH_WADDR;
            else begin
               ec_phase = PH_IDLE;
               r.protocol_error = 1'b1;
            end
         end
         HOST_DATA_RD: begin
            r.read_data = ec_out_buf;
            if (ec_obf) ec_obf = 1'b0;
            else r.protocol_error = 1'b1;
         end
         default: begin
            ec_cmd_flag = 1'b0;
            case (ec_phase)
               PH_RADDR: begin
                  ec_out_buf = ec_regs[b[ADDR_BITS-1:0]];
                  ec_obf     = 1'b1;
                  ec_phase   = PH_IDLE;
                  loads++;
               end
               PH_WADDR: begin
                  ec_wr_addr = b[ADDR_BITS-1:0];
                  ec_phase   = PH_WDATA;
               end
               PH_WDATA: begin
                  ec_regs[ec_wr_addr] = b;
                  ec_phase = PH_IDLE;
                  stores++;
               end
               default: r.protocol_error = 1'b1;
            endcase
         end
      endcase
      if (r.protocol_error) flagged++;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   // Issue one host access; called at a rising edge, returns at its acceptance
   task automatic host_access(host_op_type op, logic [7:0] b, logic typed = 1'b0,
                              logic [7:0] t_rd = 8'h00, logic t_err = 1'b0);
      int            gap;
      ec_result_type r;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= op;
      req_write_data <= b;
      do @(posedge clock); while (!req_ready);
      r = ec_decode(op, b);
      if (typed) begin
         r.read_data      = t_rd;
         r.protocol_error = t_err;
      end
      pending_q.push_back(r);
      accesses++;
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_addr();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
   endfunction

   // Response side: random stall before each transaction
   initial begin
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses++;
         got_result = '{rsp_read_data, rsp_protocol_error};
         if (pending_q.size() == 0) begin
            report_mismatch("response with nothing pending", got_result, 0);
         end else begin
            want_result = pending_q.pop_front();
            if (got_result.read_data !== want_result.read_data)
               report_mismatch("read_data", got_result.read_data, want_result.read_data);
            if (got_result.protocol_error !== want_result.protocol_error)
               report_mismatch("protocol_error", got_result.protocol_error,
                               want_result.protocol_error);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("acpi_ec_host_interface: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      int         kind;
      int         start_count;
      logic [7:0] b;
      ec_clear_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         host_access(directed[i].op, directed[i].byte_in, directed[i].typed,
                     directed[i].read_data, directed[i].protocol_error);
      drain_pending();

      // Random part: mostly well-formed store/load sequences, some noise
      start_count = accesses;
      while (accesses - start_count < RANDOM_ACCESSES) begin
         if ((accesses - start_count) % 100 < 4)
            calm = ($urandom_range(0, 3) == 0);
         if (accesses - start_count >= RANDOM_ACCESSES / 2 &&
             accesses - start_count < RANDOM_ACCESSES / 2 + 4)
            drain_pending();
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               host_access(HOST_CMD_WR, EC_CMD_WRITE);
               host_access(HOST_DATA_WR, pick_addr());
               host_access(HOST_DATA_WR, 8'($urandom_range(0, 255)));
            end
            3, 4, 5: begin
               host_access(HOST_CMD_WR, EC_CMD_READ);
               host_access(HOST_DATA_WR, pick_addr());
               if ($urandom_range(0, 1)) host_access(HOST_STATUS_RD, 8'($urandom));
               if ($urandom_range(0, 4) != 0) host_access(HOST_DATA_RD, 8'($urandom));
            end
            6: begin
               host_access(HOST_STATUS_RD, 8'($urandom));
            end
            default: begin
               b = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 1))
                  b = $urandom_range(0, 1) ? EC_CMD_READ : EC_CMD_WRITE;
               host_access(host_op_type'($urandom_range(0, 3)), b);
            end
         endcase
      end
      calm = 1'b0;
      drain_pending();
      repeat (10) @(posedge clock);

      $display("covered %0d host accesses, %0d responses checked", accesses, responses);
      $display("register stores %0d, loads %0d, protocol errors expected %0d",
               stores, loads, flagged);
      if (mismatches == 0) begin
         $display("acpi_ec_host_interface: match");
      end else begin
         $display("acpi_ec_host_interface: mismatch");
      end
      $finish;
   end

endmodule
